### hw/rtl/bit_matrix_transpose_top_defines.svh
// assertion macros for the bit matrix transpose block
`ifndef BIT_MATRIX_TRANSPOSE_TOP_DEFINES_SVH
`define BIT_MATRIX_TRANSPOSE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BMT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmt assertion failed");

// next-cycle implication, checked out of reset
`define BMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmt assertion failed");

`endif

### hw/rtl/bmt_pkg.sv
// package: constants, codes and types of the bit matrix transpose block
`default_nettype none
package bmt_pkg;

   localparam int DEF_MAX_ROWS = 256;
   localparam int DEF_MAX_COLS = 1024;

   localparam int BANKS = 8;

   localparam int ROW_COUNT_W = 9;
   localparam int COL_COUNT_W = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_INDEX_W = 1;

   localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RESET = 9'd256;
   localparam logic [COL_COUNT_W-1:0] COL_COUNT_RESET = 11'd1024;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam int SRC_ROW_W    = 8;
   localparam int SRC_OFFSET_W = 7;
   localparam int DATA_W       = 8;
   localparam int DST_COL_W    = 10;
   localparam int DST_OFFSET_W = 5;

   // read stage: which rows count, which column bit to pick and the range flag
   typedef struct packed {
      logic [BANKS-1:0] row_mask;
      logic [2:0]       bit_sel;
      logic             range_error;
   } rd_stage_type;

endpackage
`default_nettype wire

### hw/rtl/bmt_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module bmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/bit_matrix_transpose_top.sv
// top level: bit matrix store in eight row banks with transposed byte reads
//
// req_ channel takes items: kind load writes data_byte to source row src_row,
// byte src_offset; kind read returns on rsp_ one transposed byte for column
// dst_col, source rows 8*dst_offset to 8*dst_offset+7, and a range flag.
// Loads give no result. Source row r lives in bank r mod 8, so a read
// fetches all eight rows of its byte in one access of the eight banks.
// One item is taken every cycle while req_ready is high, loads and reads mixed in any order.
// A read's result goes from the bank read register and the read stage, both
// loaded at its accept edge, into the output register, which loads when the
// read stage moves on; rsp_valid rises when the output register holds it.
// When rsp_ready is low a valid output register holds, the read stage holds one
// more item, and req_ready falls only when both are full.
// reset clears the handshake state and sets row_count to 256 and col_count
// to 1024; the banks are not cleared and need no pass after reset.
// csr_ writes set row_count (index 0) and col_count (index 1); the user must make them
// only while no item is in flight, which the block itself does not enforce.
`default_nettype none
`include "bit_matrix_transpose_top_defines.svh"
module bit_matrix_transpose_top #(
   parameter int MAX_ROWS = bmt_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bmt_pkg::DEF_MAX_COLS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              csr_we,
   input  wire logic [bmt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bmt_pkg::CSR_DATA_W-1:0]    csr_wdata,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_kind,
   input  wire logic [bmt_pkg::SRC_ROW_W-1:0]     req_src_row,
   input  wire logic [bmt_pkg::SRC_OFFSET_W-1:0]  req_src_offset,
   input  wire logic [bmt_pkg::DATA_W-1:0]        req_data_byte,
   input  wire logic [bmt_pkg::DST_COL_W-1:0]     req_dst_col,
   input  wire logic [bmt_pkg::DST_OFFSET_W-1:0]  req_dst_offset,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [bmt_pkg::DATA_W-1:0]        rsp_out_byte,
   output logic                                   rsp_range_error
);

   import bmt_pkg::*;

   localparam int ROW_BYTES  = (MAX_COLS + 7) / 8;
   localparam int BANK_ROWS  = (MAX_ROWS + 7) / 8;
   localparam int BANK_DEPTH = BANK_ROWS * ROW_BYTES;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [ROW_COUNT_W-1:0] row_count_ff, row_count_in;
   logic [COL_COUNT_W-1:0] col_count_ff, col_count_in;

   logic                   req_accept;
   logic                   load_ok;
   logic [BANKS-1:0]       bank_we;
   logic [AW-1:0]          wr_addr;
   logic [AW-1:0]          rd_addr;
   logic                   rd_en;
   logic [DATA_W-1:0]      rd_data [BANKS];
   logic [31:0]            wr_lin;
   logic [31:0]            rd_lin;
   logic [31:0]            first_row;

   rd_stage_type           stage_in, stage_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_go;
   logic [DATA_W-1:0]      s1_byte;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                   rsp_err_ff, rsp_err_in;

   // configuration registers
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata[ROW_COUNT_W-1:0];
            CSR_COL_COUNT: col_count_in = csr_wdata[COL_COUNT_W-1:0];
            default:       row_count_in = row_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= ROW_COUNT_RESET;
         col_count_ff <= COL_COUNT_RESET;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // handshake: the read stage moves on when the output register frees up
   assign s1_go      = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_go;
   assign req_accept = req_valid && req_ready;

   // load path: bank picked by the low row bits
   always_comb begin
      wr_lin  = 32'(req_src_row >> 3) * 32'(ROW_BYTES) + 32'(req_src_offset);
      wr_addr = wr_lin[AW-1:0];
      load_ok = (32'(req_src_row) < 32'(MAX_ROWS)) &&
                (32'(req_src_offset) < 32'(ROW_BYTES));
      bank_we = '0;
      if (req_accept && (req_kind == KIND_LOAD) && load_ok) begin
         bank_we[req_src_row[2:0]] = 1'b1;
      end
   end

   // read path: same address in all banks, row mask and range check
   always_comb begin
      rd_lin    = 32'(req_dst_offset) * 32'(ROW_BYTES) + 32'(req_dst_col >> 3);
      rd_addr   = rd_lin[AW-1:0];
      rd_en     = req_accept && (req_kind == KIND_READ);
      first_row = 32'(req_dst_offset) << 3;
      stage_in.bit_sel     = req_dst_col[2:0];
      stage_in.range_error = (32'(req_dst_col) >= 32'(col_count_ff)) ||
                             (32'(req_dst_col) >= 32'(MAX_COLS)) ||
                             (first_row >= 32'(row_count_ff)) ||
                             (first_row >= 32'(MAX_ROWS));
      for (int k = 0; k < BANKS; k++) begin
         stage_in.row_mask[k] = !stage_in.range_error &&
                                ((first_row + 32'(k)) < 32'(row_count_ff)) &&
                                ((first_row + 32'(k)) < 32'(MAX_ROWS));
      end
   end

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      bmt_ram #(
         .WIDTH (DATA_W),
         .DEPTH (BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (wr_addr),
         .wr_data (req_data_byte),
         .rd_en   (rd_en),
         .rd_addr (rd_addr),
         .rd_data (rd_data[b])
      );
   end

   always_comb begin
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         stage_ff <= stage_in;
      end
   end

   // pick the column bit out of each bank's byte
   always_comb begin
      for (int k = 0; k < BANKS; k++) begin
         s1_byte[k] = stage_ff.row_mask[k] & rd_data[k][stage_ff.bit_sel];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_err_in   = rsp_err_ff;
      if (s1_go) begin
         rsp_valid_in = s1_valid_ff;
         rsp_byte_in  = s1_byte;
         rsp_err_in   = stage_ff.range_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_range_error = rsp_err_ff;

   `BMT_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_range_error, rsp_out_byte == '0)
   `BMT_ASSERT_NOW(a_one_bank, clock, reset, 1'b1, $onehot0(bank_we))
   `BMT_ASSERT_NEXT(a_read_held, clock, reset, rd_en, s1_valid_ff)
   `BMT_ASSERT_NOW(a_no_take_full, clock, reset, s1_valid_ff && !s1_go, !req_ready)

endmodule
`default_nettype wire

### tb/bit_matrix_transpose_checker.sv
// checker: shadows the bit matrix, predicts transposed reads and compares each result
`timescale 1ns / 1ps
module bit_matrix_transpose_checker #(
   parameter int MAX_ROWS = bmt_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = bmt_pkg::DEF_MAX_COLS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bmt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bmt_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [bmt_pkg::SRC_ROW_W-1:0]        req_src_row,
   input  logic [bmt_pkg::SRC_OFFSET_W-1:0]     req_src_offset,
   input  logic [bmt_pkg::DATA_W-1:0]           req_data_byte,
   input  logic [bmt_pkg::DST_COL_W-1:0]        req_dst_col,
   input  logic [bmt_pkg::DST_OFFSET_W-1:0]     req_dst_offset,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [bmt_pkg::DATA_W-1:0]           rsp_out_byte,
   input  logic                                 rsp_range_error,
   output int                                   fail_count,
   output int                                   reads_pending
);
   import bmt_pkg::*;

   localparam int ROW_BYTES = (MAX_COLS + 7) / 8;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              range_error;
   } read_result_type;

   bit [DATA_W-1:0] matrix_shadow [0:MAX_ROWS-1][0:ROW_BYTES-1];
   int              row_count_set;
   int              col_count_set;
   read_result_type expected_reads [$];

   function automatic read_result_type transposed_read(logic [DST_COL_W-1:0]    col,
                                                       logic [DST_OFFSET_W-1:0] dbyte);
      read_result_type res;
      int              rows_eff;
      int              cols_eff;
      int              first;
      rows_eff = (row_count_set > MAX_ROWS) ? MAX_ROWS : row_count_set;
      cols_eff = (col_count_set > MAX_COLS) ? MAX_COLS : col_count_set;
      first    = int'(dbyte) * 8;
      res      = '0;
      if (int'(col) >= cols_eff || first >= rows_eff) begin
         res.range_error = 1'b1;
      end else begin
         // rows past the configured count contribute zero bits
         for (int k = 0; k < 8; k++) begin
            if (first + k < rows_eff) begin
               res.out_byte[k] = matrix_shadow[first + k][col >> 3][col[2:0]];
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : track
      read_result_type want;
      if (reset) begin
         row_count_set = int'(ROW_COUNT_RESET);
         col_count_set = int'(COL_COUNT_RESET);
         fail_count    = 0;
         expected_reads.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ROW_COUNT) begin
               row_count_set = int'(csr_wdata[ROW_COUNT_W-1:0]);
            end else if (csr_index == CSR_COL_COUNT) begin
               col_count_set = int'(csr_wdata[COL_COUNT_W-1:0]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reads.size() == 0) begin
               $error("item with no read outstanding: out_byte %02h range_error %0b",
                      rsp_out_byte, rsp_range_error);
               fail_count++;
            end else begin
               want = expected_reads.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_range_error !== want.range_error) begin
                  $error("range_error: expected %0b, actual %0b",
                         want.range_error, rsp_range_error);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_LOAD) begin
               if (int'(req_src_row) < MAX_ROWS && int'(req_src_offset) < ROW_BYTES) begin
                  matrix_shadow[req_src_row][req_src_offset] = req_data_byte;
               end
            end else begin
               expected_reads.push_back(transposed_read(req_dst_col, req_dst_offset));
            end
         end
      end
      reads_pending = expected_reads.size();
   end

endmodule

### tb/testbench.sv
// testbench top: clock, reset, stimulus and verdict for the bit matrix transpose block
`timescale 1ns / 1ps
module testbench;
   import bmt_pkg::*;

   localparam int ROWS        = DEF_MAX_ROWS;
   localparam int COLS        = DEF_MAX_COLS;
   localparam int ROW_BYTES   = COLS / 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 75;

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    csr_we          = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index       = CSR_ROW_COUNT;
   logic [CSR_DATA_W-1:0]   csr_wdata       = '0;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic                    req_kind        = KIND_LOAD;
   logic [SRC_ROW_W-1:0]    req_src_row     = '0;
   logic [SRC_OFFSET_W-1:0] req_src_offset  = '0;
   logic [DATA_W-1:0]       req_data_byte   = '0;
   logic [DST_COL_W-1:0]    req_dst_col     = '0;
   logic [DST_OFFSET_W-1:0] req_dst_offset  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b1;
   logic [DATA_W-1:0]       rsp_out_byte;
   logic                    rsp_range_error;

   int  fail_count;
   int  reads_pending;
   logic req_took    = 1'b0;
   bit  gaps_on      = 1'b1;
   int  stall_left   = 0;
   int  quiet_cycles = 0;
   int  items_sent   = 0;
   int  rows_eff     = ROWS;
   int  cols_eff     = COLS;
   bit  loaded [0:ROWS-1][0:ROW_BYTES-1];

   // register settings per phase, extremes and oversized values among them
   int  phase_rows [0:PHASES-1] = '{256, 3, 511, 0, 13, 1, 205, 256};
   int  phase_cols [0:PHASES-1] = '{1024, 1024, 2047, 17, 0, 1, 700, 1024};

   bit_matrix_transpose_top u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_src_row     (req_src_row),
      .req_src_offset  (req_src_offset),
      .req_data_byte   (req_data_byte),
      .req_dst_col     (req_dst_col),
      .req_dst_offset  (req_dst_offset),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_range_error (rsp_range_error)
   );

   bit_matrix_transpose_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_src_row     (req_src_row),
      .req_src_offset  (req_src_offset),
      .req_data_byte   (req_data_byte),
      .req_dst_col     (req_dst_col),
      .req_dst_offset  (req_dst_offset),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_range_error (rsp_range_error),
      .fail_count      (fail_count),
      .reads_pending   (reads_pending)
   );

   always #5 clock = ~clock;

   // acceptance seen at the rising edge, read back at the following falling edge
   always @(posedge clock) begin
      req_took <= req_valid && req_ready;
   end

   // result side stalls in short random bursts
   always @(negedge clock) begin
      if (stall_left == 0 && gaps_on && $urandom_range(99) < 2) begin
         stall_left = $urandom_range(5, 1);
      end
      rsp_ready = (stall_left == 0);
      if (stall_left > 0) begin
         stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("bit_matrix_transpose_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(logic kind, logic [SRC_ROW_W-1:0] row,
                            logic [SRC_OFFSET_W-1:0] sbyte, logic [DATA_W-1:0] data,
                            logic [DST_COL_W-1:0] col, logic [DST_OFFSET_W-1:0] dbyte);
      while (gaps_on && $urandom_range(99) < 6) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_kind       = kind;
      req_src_row    = row;
      req_src_offset = sbyte;
      req_data_byte  = data;
      req_dst_col    = col;
      req_dst_offset = dbyte;
      do @(negedge clock); while (!req_took);
      items_sent++;
   endtask

   task automatic load_byte(int row, int sbyte, logic [DATA_W-1:0] data);
      send_item(KIND_LOAD, SRC_ROW_W'(row), SRC_OFFSET_W'(sbyte), data,
                DST_COL_W'($urandom), DST_OFFSET_W'($urandom));
      loaded[row][sbyte] = 1'b1;
   endtask

   // any in-range source byte the read touches gets loaded first
   task automatic read_byte(int col, int dbyte);
      int first;
      int last;
      first = dbyte * 8;
      if (col < cols_eff && first < rows_eff) begin
         last = (first + 7 < rows_eff) ? first + 7 : rows_eff - 1;
         for (int r = first; r <= last; r++) begin
            if (!loaded[r][col / 8]) begin
               load_byte(r, col / 8, DATA_W'($urandom));
            end
         end
      end
      send_item(KIND_READ, SRC_ROW_W'($urandom), SRC_OFFSET_W'($urandom),
                DATA_W'($urandom), DST_COL_W'(col), DST_OFFSET_W'(dbyte));
   endtask

   task automatic reconfigure(logic [CSR_DATA_W-1:0] rows, logic [CSR_DATA_W-1:0] cols);
      req_valid = 1'b0;
      while (reads_pending != 0) @(negedge clock);
      // let loads still in the pipe drain
      repeat (4) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_ROW_COUNT;
      csr_wdata = rows;
      @(negedge clock);
      csr_index = CSR_COL_COUNT;
      csr_wdata = cols;
      @(negedge clock);
      csr_we    = 1'b0;
      rows_eff  = (int'(rows[ROW_COUNT_W-1:0]) > ROWS) ? ROWS : int'(rows[ROW_COUNT_W-1:0]);
      cols_eff  = (int'(cols[COL_COUNT_W-1:0]) > COLS) ? COLS : int'(cols[COL_COUNT_W-1:0]);
   endtask

   task automatic random_run(int count);
      int stop_at;
      int pick;
      int grp;
      int cb;
      int rot;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            // fill eight source rows of one byte column, then read columns across it
            grp = (rows_eff > 0 && $urandom_range(9) < 8) ?
                  $urandom_range((rows_eff - 1) / 8) : $urandom_range(31);
            cb  = (cols_eff > 0 && $urandom_range(9) < 8) ?
                  $urandom_range((cols_eff - 1) / 8) : $urandom_range(ROW_BYTES - 1);
            rot = $urandom_range(7);
            for (int k = 0; k < 8; k++) begin
               load_byte(grp * 8 + (k + rot) % 8, cb, DATA_W'($urandom));
            end
            repeat ($urandom_range(8, 1)) read_byte(cb * 8 + $urandom_range(7), grp);
         end else if (pick < 80) begin
            load_byte($urandom_range(ROWS - 1), $urandom_range(ROW_BYTES - 1),
                      DATA_W'($urandom));
         end else begin
            read_byte($urandom_range(COLS - 1), $urandom_range(31));
         end
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // both corners of the matrix, shifted runs of ones and single-bit patterns
      for (int k = 0; k < 8; k++) begin
         load_byte(k, 0, 8'hFF >> k);
      end
      read_byte(0, 0);
      read_byte(7, 0);
      for (int k = 0; k < 8; k++) begin
         load_byte(ROWS - 8 + k, ROW_BYTES - 1, 8'h01 << k);
      end
      read_byte(COLS - 1, 31);
      read_byte(COLS - 8, 31);

      // row count not a multiple of eight, and a read past it
      reconfigure(CSR_DATA_W'(3), CSR_DATA_W'(1024));
      read_byte(0, 0);
      read_byte(0, 1);

      for (int p = 0; p < PHASES; p++) begin
         gaps_on = (p != 2);
         reconfigure(CSR_DATA_W'(phase_rows[p]), CSR_DATA_W'(phase_cols[p]));
         random_run(PHASE_ITEMS);
      end

      req_valid = 1'b0;
      gaps_on   = 1'b1;
      while (reads_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("bit_matrix_transpose_top test passed");
      end else begin
         $display("bit_matrix_transpose_top test failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bmt_pkg.sv
hw/rtl/bmt_ram.sv
hw/rtl/bit_matrix_transpose_top.sv
tb/bit_matrix_transpose_checker.sv
tb/testbench.sv
